@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the row program sequencer blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ src/rpss_pkg.sv @@
// ----------------------------------------------------------------------------
// rpss_pkg
// Types, codes and helper functions of the row program step sequencer.
// ----------------------------------------------------------------------------
package rpss_pkg;

    localparam int PROGRAM_DEPTH = 32;
    localparam int COLUMNS       = 8;
    localparam int NUM_CELLS     = 32;

    localparam int PROG_AW  = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
    localparam int PLEN_W   = $clog2(PROGRAM_DEPTH + 1);
    localparam int COL_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int LEN_W    = $clog2(COLUMNS + 1);
    localparam int ROW_W    = 2;
    localparam int CELL_W   = 5;
    localparam int ENTRY_W  = 4;
    localparam int ENTRY_BWD = 3;

    localparam int FUNC_W   = 3;
    localparam int KIND_W   = 3;
    localparam int RLEN_W   = 4;
    localparam int PLCFG_W  = 6;
    localparam int MODE_W   = 2;
    localparam int TICKS_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Item functions.
    localparam logic [FUNC_W-1:0] FUNC_CLOCK  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_RESET  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TOGGLE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd5;

    // Row kinds of a program entry.
    localparam logic [KIND_W-1:0] KIND_A     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_B     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_C     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_D     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OTHER = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ANY   = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LEN_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LEN_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LEN_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LEN_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_MODE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE  = 3'd7;

    // Gate modes; the remaining codes behave as continuous gate.
    localparam logic [MODE_W-1:0] MODE_TRIGGER   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RETRIGGER = 2'd1;

    // Register reset values.
    localparam logic [RLEN_W-1:0]  ROW_LEN_RESET     = 4'd4;
    localparam logic [PLCFG_W-1:0] PROG_LEN_RESET    = 6'd4;
    localparam logic [MODE_W-1:0]  GATE_MODE_RESET   = MODE_TRIGGER;
    localparam logic [TICKS_W-1:0] PULSE_TICKS_RESET = 16'd4800;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [4:0]        cell_req;
        logic [4:0]        slot;
        logic [KIND_W-1:0] row_kind;
        logic              backward;
        logic [7:0]        random_value;
        logic [31:0]       gate_mask;
    } item_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_index;
        logic              gate_out;
        logic              advanced;
    } result_t;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic [PROG_AW-1:0]   pidx;
        logic                 reset_pending;
        logic [NUM_CELLS-1:0] gates;
        logic [TICKS_W-1:0]   pulse;
    } seq_state_t;

    typedef struct packed {
        logic [3:0][RLEN_W-1:0] row_len;
        logic [PLEN_W-1:0]      plen;
        logic [MODE_W-1:0]      gate_mode;
        logic [TICKS_W-1:0]     pulse_ticks;
        logic                   run;
    } seq_cfg_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry_cur;
        logic [ENTRY_W-1:0] entry_next;
        logic [ENTRY_W-1:0] entry_first;
    } prog_rd_t;

    typedef struct packed {
        logic               en;
        logic [PROG_AW-1:0] addr;
        logic [ENTRY_W-1:0] data;
    } prog_wr_t;

    // Program length as used, saturated to the program depth.
    function automatic logic [PLEN_W-1:0] sat_plen(input logic [PLCFG_W-1:0] v);
        logic [PLEN_W-1:0] r;
        begin
            if (int'(v) > PROGRAM_DEPTH) r = PLEN_W'(PROGRAM_DEPTH);
            else                         r = PLEN_W'(v);
            return r;
        end
    endfunction

    // Program index as read: past the length it reads entry 0.
    function automatic logic [PROG_AW-1:0] cur_index(input logic [PROG_AW-1:0] pidx,
                                                     input logic [PLEN_W-1:0]  plen);
        logic [PROG_AW-1:0] r;
        begin
            if (int'(pidx) < int'(plen)) r = pidx;
            else                         r = '0;
            return r;
        end
    endfunction

    // Following program index, wrapping at the length.
    function automatic logic [PROG_AW-1:0] next_index(input logic [PROG_AW-1:0] idx,
                                                      input logic [PLEN_W-1:0]  plen);
        logic [PROG_AW-1:0] r;
        begin
            if (int'(idx) + 1 >= int'(plen)) r = '0;
            else                             r = idx + PROG_AW'(1);
            return r;
        end
    endfunction

    // Row length clamped to one..COLUMNS.
    function automatic logic [LEN_W-1:0] row_len_clamp(input logic [RLEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        begin
            if (v == '0)                 r = LEN_W'(1);
            else if (int'(v) > COLUMNS)  r = LEN_W'(COLUMNS);
            else                         r = LEN_W'(v);
            return r;
        end
    endfunction

    // Remainder by three: base-four digits sum to the same residue.
    function automatic logic [1:0] mod3_u8(input logic [7:0] v);
        logic [3:0] s;
        logic [1:0] r;
        begin
            s = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} + {2'b00, v[7:6]};
            case (s)
                4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = 2'd0;
                4'd1, 4'd4, 4'd7, 4'd10:       r = 2'd1;
                4'd2, 4'd5, 4'd8, 4'd11:       r = 2'd2;
                default:                       r = 2'd0;
            endcase
            return r;
        end
    endfunction

    // Row chosen by a program entry.
    function automatic logic [ROW_W-1:0] pick_row(input logic [ENTRY_W-1:0] entry,
                                                  input logic [7:0]         rnd,
                                                  input logic [ROW_W-1:0]   row);
        logic [ROW_W-1:0] r;
        begin
            case (entry[KIND_W-1:0])
                KIND_A, KIND_B, KIND_C, KIND_D: r = entry[ROW_W-1:0];
                KIND_OTHER: r = row + ROW_W'(1) + mod3_u8(rnd);
                KIND_ANY:   r = rnd[ROW_W-1:0];
                default:    r = '0;
            endcase
            return r;
        end
    endfunction

    // First column of a row entered under a program entry.
    function automatic logic [COL_W-1:0] first_col(input logic [ENTRY_W-1:0] entry,
                                                   input logic [RLEN_W-1:0]  len_cfg);
        logic [LEN_W-1:0] l;
        logic [COL_W-1:0] r;
        begin
            l = row_len_clamp(len_cfg);
            if (entry[ENTRY_BWD]) r = COL_W'(l - LEN_W'(1));
            else                  r = '0;
            return r;
        end
    endfunction

    // Program store contents after reset: entry three selects row B.
    function automatic logic [ENTRY_W-1:0] reset_entry(input logic [PROG_AW-1:0] addr);
        logic [ENTRY_W-1:0] r;
        begin
            if (PROGRAM_DEPTH > 3 && int'(addr) == 3) r = ENTRY_W'(KIND_B);
            else                                      r = ENTRY_W'(KIND_A);
            return r;
        end
    endfunction

endpackage

@@ src/rpss_item_if.sv @@
// ----------------------------------------------------------------------------
// rpss_item_if
// Input item channel of the row program step sequencer.
// ----------------------------------------------------------------------------
interface rpss_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [4:0] cell_req;
    logic [4:0] slot;
    logic [2:0] row_kind;
    logic       backward;
    logic [7:0] random_value;
    logic [31:0] gate_mask;

    modport source (output valid, func, cell_req, slot, row_kind, backward,
                    random_value, gate_mask, input ready);
    modport sink   (input valid, func, cell_req, slot, row_kind, backward,
                    random_value, gate_mask, output ready);
endinterface

@@ src/rpss_result_if.sv @@
// ----------------------------------------------------------------------------
// rpss_result_if
// Result channel of the row program step sequencer.
// ----------------------------------------------------------------------------
interface rpss_result_if;
    logic       valid;
    logic       ready;
    logic [4:0] cell_index;
    logic       gate_out;
    logic       advanced;

    modport source (output valid, cell_index, gate_out, advanced, input ready);
    modport sink   (input valid, cell_index, gate_out, advanced, output ready);
endinterface

@@ src/rpss_cfg_if.sv @@
// ----------------------------------------------------------------------------
// rpss_cfg_if
// Configuration write channel of the row program step sequencer.
// ----------------------------------------------------------------------------
interface rpss_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/rpss_ram.sv @@
// ----------------------------------------------------------------------------
// rpss_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module rpss_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                         rdata_a,
    output logic [WIDTH-1:0]                         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-before-write on a shared address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ src/rpss_step.sv @@
// ----------------------------------------------------------------------------
// rpss_step
// Next-state and result logic for one item of the step sequencer.
// ----------------------------------------------------------------------------
module rpss_step (
    input  rpss_pkg::seq_cfg_t   cfg,
    input  rpss_pkg::seq_state_t st,
    input  rpss_pkg::item_t      it,
    input  rpss_pkg::prog_rd_t   rd,
    output rpss_pkg::seq_state_t nxt,
    output rpss_pkg::result_t    res,
    output rpss_pkg::prog_wr_t   wr
);

    logic [rpss_pkg::PROG_AW-1:0] idx;
    logic [rpss_pkg::PROG_AW-1:0] nidx;
    logic                         has_prog;
    logic                         fwd;
    logic                         at_end;
    logic [rpss_pkg::LEN_W-1:0]   len;
    logic [rpss_pkg::ROW_W-1:0]   row1;
    logic [rpss_pkg::COL_W-1:0]   col1;
    logic [rpss_pkg::PROG_AW-1:0] pidx1;
    logic [rpss_pkg::ROW_W-1:0]   row2;
    logic [rpss_pkg::COL_W-1:0]   col2;
    logic [rpss_pkg::PROG_AW-1:0] pidx2;
    logic                         pulse_lvl;
    logic                         gate;
    logic [rpss_pkg::CELL_W-1:0]  cell_idx;

    always_comb
    begin
        idx      = rpss_pkg::cur_index(st.pidx, cfg.plen);
        nidx     = rpss_pkg::next_index(idx, cfg.plen);
        has_prog = (cfg.plen != '0);
        fwd      = has_prog ? !rd.entry_cur[rpss_pkg::ENTRY_BWD] : 1'b1;
        len      = rpss_pkg::row_len_clamp(cfg.row_len[st.row]);

        // One column step in the direction of the current entry.
        row1   = st.row;
        col1   = st.col;
        pidx1  = st.pidx;
        at_end = 1'b0;
        if (fwd)
        begin
            if (int'(st.col) + 1 < int'(len)) col1 = st.col + rpss_pkg::COL_W'(1);
            else                              at_end = 1'b1;
        end
        else
        begin
            if (st.col != '0) col1 = st.col - rpss_pkg::COL_W'(1);
            else              at_end = 1'b1;
        end

        // At the row end the following entry picks the row.
        if (at_end)
        begin
            if (!has_prog)
            begin
                row1  = st.row + rpss_pkg::ROW_W'(1);
                col1  = '0;
                pidx1 = '0;
            end
            else
            begin
                row1  = rpss_pkg::pick_row(rd.entry_next, it.random_value, st.row);
                col1  = rpss_pkg::first_col(rd.entry_next, cfg.row_len[row1]);
                pidx1 = nidx;
            end
        end

        // A pending reset request sends the position to the program start.
        row2  = row1;
        col2  = col1;
        pidx2 = pidx1;
        if (st.reset_pending)
        begin
            pidx2 = '0;
            if (has_prog)
            begin
                row2 = rpss_pkg::pick_row(rd.entry_first, it.random_value, row1);
                col2 = rpss_pkg::first_col(rd.entry_first, cfg.row_len[row2]);
            end
            else
            begin
                row2 = '0;
            end
        end

        nxt       = st;
        wr.en     = 1'b0;
        wr.addr   = rpss_pkg::PROG_AW'(it.slot);
        wr.data   = {it.backward, it.row_kind};
        res.advanced = 1'b0;
        pulse_lvl = (st.pulse != '0);

        case (it.func)
            rpss_pkg::FUNC_CLOCK:
            begin
                if (cfg.run)
                begin
                    res.advanced      = 1'b1;
                    nxt.row           = row2;
                    nxt.col           = col2;
                    nxt.pidx          = pidx2;
                    nxt.reset_pending = 1'b0;
                    nxt.pulse = (cfg.pulse_ticks > st.pulse) ? cfg.pulse_ticks : st.pulse;
                    pulse_lvl = (nxt.pulse != '0);
                end
            end
            rpss_pkg::FUNC_RESET:
            begin
                nxt.reset_pending = 1'b1;
            end
            rpss_pkg::FUNC_TOGGLE:
            begin
                nxt.gates = st.gates ^ (rpss_pkg::NUM_CELLS'(1) << it.cell_req);
            end
            rpss_pkg::FUNC_WRITE:
            begin
                wr.en = (int'(it.slot) < rpss_pkg::PROGRAM_DEPTH);
            end
            rpss_pkg::FUNC_LOAD:
            begin
                nxt.gates = it.gate_mask;
            end
            rpss_pkg::FUNC_TICK:
            begin
                if (st.pulse != '0) nxt.pulse = st.pulse - rpss_pkg::TICKS_W'(1);
            end
            default:
            begin
            end
        endcase

        cell_idx = rpss_pkg::CELL_W'(int'(nxt.col) + int'(nxt.row) * rpss_pkg::COLUMNS);
        gate = cfg.run && nxt.gates[cell_idx];
        case (cfg.gate_mode)
            rpss_pkg::MODE_TRIGGER:   gate = gate && pulse_lvl;
            rpss_pkg::MODE_RETRIGGER: gate = gate && !pulse_lvl;
            default:                  gate = gate;
        endcase

        res.cell_index = cell_idx;
        res.gate_out   = gate;
    end

endmodule

@@ src/row_program_step_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// row_program_step_sequencer_unit
// Path: a transfer accepted into the input register passes through the step
// logic into the result register before it is offered on the result channel.
// Throughput: one item per cycle while the result channel does not stall and no
// configuration write is pending; the program store is read ahead of each item.
// Reset: registers, play position and gate bits reset at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module row_program_step_sequencer_unit (
    input logic         clk,
    input logic         rst_n,
    rpss_cfg_if.sink    cfg,
    rpss_item_if.sink   item,
    rpss_result_if.source result
);

    // ------------------------------------------------------------------
    // Configuration registers. The port is always ready; writes must arrive
    // only while the block is idle, which the block does not enforce.
    // ------------------------------------------------------------------
    logic [3:0][rpss_pkg::RLEN_W-1:0] row_len_reg;
    logic [rpss_pkg::PLCFG_W-1:0]     prog_len_reg;
    logic [rpss_pkg::MODE_W-1:0]      gate_mode_reg;
    logic [rpss_pkg::TICKS_W-1:0]     pulse_ticks_reg;
    logic                             run_enable_reg;
    rpss_pkg::seq_cfg_t               cfg_s;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_len_reg     <= {4{rpss_pkg::ROW_LEN_RESET}};
            prog_len_reg    <= rpss_pkg::PROG_LEN_RESET;
            gate_mode_reg   <= rpss_pkg::GATE_MODE_RESET;
            pulse_ticks_reg <= rpss_pkg::PULSE_TICKS_RESET;
            run_enable_reg  <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                rpss_pkg::CFG_ROW_LEN_A:   row_len_reg[0]  <= cfg.data[rpss_pkg::RLEN_W-1:0];
                rpss_pkg::CFG_ROW_LEN_B:   row_len_reg[1]  <= cfg.data[rpss_pkg::RLEN_W-1:0];
                rpss_pkg::CFG_ROW_LEN_C:   row_len_reg[2]  <= cfg.data[rpss_pkg::RLEN_W-1:0];
                rpss_pkg::CFG_ROW_LEN_D:   row_len_reg[3]  <= cfg.data[rpss_pkg::RLEN_W-1:0];
                rpss_pkg::CFG_PROG_LEN:    prog_len_reg    <= cfg.data[rpss_pkg::PLCFG_W-1:0];
                rpss_pkg::CFG_GATE_MODE:   gate_mode_reg   <= cfg.data[rpss_pkg::MODE_W-1:0];
                rpss_pkg::CFG_PULSE_TICKS: pulse_ticks_reg <= cfg.data[rpss_pkg::TICKS_W-1:0];
                rpss_pkg::CFG_RUN_ENABLE:  run_enable_reg  <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg_s.row_len     = row_len_reg;
        cfg_s.plen        = rpss_pkg::sat_plen(prog_len_reg);
        cfg_s.gate_mode   = gate_mode_reg;
        cfg_s.pulse_ticks = pulse_ticks_reg;
        cfg_s.run         = run_enable_reg;
    end

    // ------------------------------------------------------------------
    // Handshake. The input register takes a new transfer whenever it is
    // empty or its item moves on to the result register in the same cycle.
    // A pending configuration write holds off input while it is valid so that
    // the program store reads ahead with the new program length.
    // ------------------------------------------------------------------
    logic            stage_valid_reg;
    logic            stage_valid_next;
    rpss_pkg::item_t stage_item_reg;
    logic            stage_fire;
    logic            accept;
    logic            res_valid_reg;
    logic            res_valid_next;
    rpss_pkg::result_t res_reg;

    assign stage_fire = stage_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !cfg.valid && (!stage_valid_reg || stage_fire);
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        if (accept)          stage_valid_next = 1'b1;
        else if (stage_fire) stage_valid_next = 1'b0;
        else                 stage_valid_next = stage_valid_reg;

        if (stage_fire)        res_valid_next = 1'b1;
        else if (result.ready) res_valid_next = 1'b0;
        else                   res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg.func         <= item.func;
            stage_item_reg.cell_req     <= item.cell_req;
            stage_item_reg.slot         <= item.slot;
            stage_item_reg.row_kind     <= item.row_kind;
            stage_item_reg.backward     <= item.backward;
            stage_item_reg.random_value <= item.random_value;
            stage_item_reg.gate_mask    <= item.gate_mask;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state: play position, program index, pending reset,
    // cell gate bits and the pulse counter.
    // ------------------------------------------------------------------
    rpss_pkg::seq_state_t st_reg;
    rpss_pkg::seq_state_t st_next;
    rpss_pkg::seq_state_t step_nxt;
    rpss_pkg::result_t    step_res;
    rpss_pkg::prog_wr_t   step_wr;
    rpss_pkg::prog_rd_t   prog_rd;

    rpss_step u_step (
        .cfg (cfg_s),
        .st  (st_reg),
        .it  (stage_item_reg),
        .rd  (prog_rd),
        .nxt (step_nxt),
        .res (step_res),
        .wr  (step_wr)
    );

    assign st_next = stage_fire ? step_nxt : st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.row           <= '0;
            st_reg.col           <= '0;
            st_reg.pidx          <= '0;
            st_reg.reset_pending <= 1'b1;
            st_reg.gates         <= '1;
            st_reg.pulse         <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire)
        begin
            res_reg <= step_res;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.cell_index = res_reg.cell_index;
    assign result.gate_out   = res_reg.gate_out;
    assign result.advanced   = res_reg.advanced;

    // ------------------------------------------------------------------
    // Program store. The RAM is read ahead at the entry that st_next points
    // to, and at the entry after it. Entries never written since reset read
    // as their reset value through per-entry valid bits, and a write to an
    // address being read is forwarded. Entry 0 is shadowed in a register for
    // the return to program start.
    // ------------------------------------------------------------------
    logic [rpss_pkg::PROG_AW-1:0]       addr_cur;
    logic [rpss_pkg::PROG_AW-1:0]       addr_nxt;
    logic                               wr_fire;
    logic [rpss_pkg::PROGRAM_DEPTH-1:0] prog_valid_reg;
    logic [rpss_pkg::ENTRY_W-1:0]       ram_cur;
    logic [rpss_pkg::ENTRY_W-1:0]       ram_nxt;
    logic                               fix_cur_reg;
    logic                               fix_cur_next;
    logic [rpss_pkg::ENTRY_W-1:0]       fix_cur_data_reg;
    logic [rpss_pkg::ENTRY_W-1:0]       fix_cur_data_next;
    logic                               fix_nxt_reg;
    logic                               fix_nxt_next;
    logic [rpss_pkg::ENTRY_W-1:0]       fix_nxt_data_reg;
    logic [rpss_pkg::ENTRY_W-1:0]       fix_nxt_data_next;
    logic [rpss_pkg::ENTRY_W-1:0]       entry0_reg;

    assign addr_cur = rpss_pkg::cur_index(st_next.pidx, cfg_s.plen);
    assign addr_nxt = rpss_pkg::next_index(addr_cur, cfg_s.plen);
    assign wr_fire  = stage_fire && step_wr.en;

    always_comb
    begin
        if (wr_fire && step_wr.addr == addr_cur)
        begin
            fix_cur_next      = 1'b1;
            fix_cur_data_next = step_wr.data;
        end
        else
        begin
            fix_cur_next      = !prog_valid_reg[addr_cur];
            fix_cur_data_next = rpss_pkg::reset_entry(addr_cur);
        end

        if (wr_fire && step_wr.addr == addr_nxt)
        begin
            fix_nxt_next      = 1'b1;
            fix_nxt_data_next = step_wr.data;
        end
        else
        begin
            fix_nxt_next      = !prog_valid_reg[addr_nxt];
            fix_nxt_data_next = rpss_pkg::reset_entry(addr_nxt);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_valid_reg   <= '0;
            fix_cur_reg      <= 1'b1;
            fix_cur_data_reg <= rpss_pkg::reset_entry('0);
            fix_nxt_reg      <= 1'b1;
            fix_nxt_data_reg <= rpss_pkg::reset_entry(rpss_pkg::PROG_AW'(1));
            entry0_reg       <= rpss_pkg::reset_entry('0);
        end
        else
        begin
            if (wr_fire)
            begin
                prog_valid_reg[step_wr.addr] <= 1'b1;
                if (step_wr.addr == '0)
                begin
                    entry0_reg <= step_wr.data;
                end
            end
            fix_cur_reg      <= fix_cur_next;
            fix_cur_data_reg <= fix_cur_data_next;
            fix_nxt_reg      <= fix_nxt_next;
            fix_nxt_data_reg <= fix_nxt_data_next;
        end
    end

    rpss_ram #(
        .WIDTH (rpss_pkg::ENTRY_W),
        .DEPTH (rpss_pkg::PROGRAM_DEPTH)
    ) u_prog_ram (
        .clk     (clk),
        .we      (wr_fire),
        .waddr   (step_wr.addr),
        .wdata   (step_wr.data),
        .raddr_a (addr_cur),
        .raddr_b (addr_nxt),
        .rdata_a (ram_cur),
        .rdata_b (ram_nxt)
    );

    assign prog_rd.entry_cur   = fix_cur_reg ? fix_cur_data_reg : ram_cur;
    assign prog_rd.entry_next  = fix_nxt_reg ? fix_nxt_data_reg : ram_nxt;
    assign prog_rd.entry_first = entry0_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_fire_gives_result, clk, rst_n, stage_fire, result.valid)

    `ASSERT_IMPLY(a_stall_blocks_input, clk, rst_n,
        stage_valid_reg && res_valid_reg && !result.ready, !item.ready)

    `ASSERT_NEXT(a_clock_clears_pending, clk, rst_n,
        stage_fire && stage_item_reg.func == rpss_pkg::FUNC_CLOCK && run_enable_reg,
        !st_reg.reset_pending && st_reg.pulse >= pulse_ticks_reg)

    `ASSERT_IMPLY(a_advance_needs_run, clk, rst_n,
        res_valid_reg && res_reg.advanced, run_enable_reg)

endmodule

@@ test/row_program_step_sequencer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// row_program_step_sequencer_unit_tb
// Self-checking bench for the row program step sequencer. Items go in on the
// item channel, and a cycle-free model of the play position, the program, the
// gate bits and the step pulse predicts every result. Results are compared
// field by field in order, under random idling on both sides, register
// settings that include the extremes, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module row_program_step_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Codes that the package leaves unnamed. The block has to treat them too.
    localparam logic [rpss_pkg::FUNC_W-1:0] FUNC_SPARE_6    = 3'd6;
    localparam logic [rpss_pkg::FUNC_W-1:0] FUNC_SPARE_7    = 3'd7;
    localparam logic [rpss_pkg::KIND_W-1:0] KIND_SPARE_6    = 3'd6;
    localparam logic [rpss_pkg::KIND_W-1:0] KIND_SPARE_7    = 3'd7;
    localparam logic [rpss_pkg::MODE_W-1:0] MODE_CONTINUOUS = 2'd2;
    localparam logic [rpss_pkg::MODE_W-1:0] MODE_SPARE      = 2'd3;

    localparam int GAP_MAX         = 6;
    localparam int HOLD_OFF_CYCLES = 200;
    // A result passes the input and result registers after its transfer. The
    // drain wait after the last result leaves the pipeline empty for writes.
    localparam int DRAIN_CYCLES    = 6;
    // The longest correct quiet stretch is the output hold-off, below the limit.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_PRINTED     = 40;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    rpss_cfg_if    cfg_bus ();
    rpss_item_if   item_bus ();
    rpss_result_if result_bus ();

    row_program_step_sequencer_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .item   (item_bus),
        .result (result_bus)
    );

    // ------------------------------------------------------------------
    // Register copy used by the model.
    // ------------------------------------------------------------------
    logic [rpss_pkg::RLEN_W-1:0]  len_reg [4];
    logic [rpss_pkg::PLCFG_W-1:0] plen_reg;
    logic [rpss_pkg::MODE_W-1:0]  mode_reg;
    logic [rpss_pkg::TICKS_W-1:0] ticks_reg;
    logic                         run_reg;

    // ------------------------------------------------------------------
    // Sequencer state used by the model.
    // ------------------------------------------------------------------
    logic [rpss_pkg::ROW_W-1:0]     play_row;
    logic [rpss_pkg::COL_W-1:0]     play_col;
    logic [rpss_pkg::PROG_AW-1:0]   prog_pos;
    logic                           restart_due;
    logic [rpss_pkg::NUM_CELLS-1:0] cell_gate;
    logic [rpss_pkg::ENTRY_W-1:0]   prog_mem [rpss_pkg::PROGRAM_DEPTH];
    logic [rpss_pkg::TICKS_W-1:0]   pulse_left;

    // Predicted results, oldest first.
    rpss_pkg::result_t awaited_results [$];
    rpss_pkg::result_t due;

    int  items_sent      = 0;
    int  results_checked = 0;
    int  reg_writes      = 0;
    int  mismatches      = 0;
    int  printed         = 0;
    int  quiet_cycles    = 0;
    int  hold_request    = 0;
    bit  steady          = 1'b0;

    // ------------------------------------------------------------------
    // Model of the block.
    // ------------------------------------------------------------------
    function automatic void reset_model();
        for (int i = 0; i < 4; i++) len_reg[i] = rpss_pkg::ROW_LEN_RESET;
        plen_reg  = rpss_pkg::PROG_LEN_RESET;
        mode_reg  = rpss_pkg::GATE_MODE_RESET;
        ticks_reg = rpss_pkg::PULSE_TICKS_RESET;
        run_reg   = 1'b1;
        play_row    = '0;
        play_col    = '0;
        prog_pos    = '0;
        restart_due = 1'b1;
        cell_gate   = '1;
        pulse_left  = '0;
        // After reset the program plays row A three times, then row B.
        for (int i = 0; i < rpss_pkg::PROGRAM_DEPTH; i++)
            prog_mem[i] = {1'b0, rpss_pkg::KIND_A};
        prog_mem[3] = {1'b0, rpss_pkg::KIND_B};
    endfunction

    // Row length as the block uses it: clamped to one up to the column count.
    function automatic int unsigned active_steps(input logic [rpss_pkg::ROW_W-1:0] r);
        int unsigned v;
        v = len_reg[r];
        if (v < 1) v = 1;
        if (v > rpss_pkg::COLUMNS) v = rpss_pkg::COLUMNS;
        return v;
    endfunction

    // Program length saturates at the store depth.
    function automatic int unsigned program_span();
        int unsigned v;
        v = plen_reg;
        if (v > rpss_pkg::PROGRAM_DEPTH) v = rpss_pkg::PROGRAM_DEPTH;
        return v;
    endfunction

    // Row named by an entry. "Other row" never lands on the current row, and
    // the spare kinds fall back to row A.
    function automatic logic [rpss_pkg::ROW_W-1:0] entry_row(
        input logic [rpss_pkg::ENTRY_W-1:0] e, input logic [7:0] rnd);
        logic [rpss_pkg::ROW_W-1:0] r;
        case (e[rpss_pkg::KIND_W-1:0])
            rpss_pkg::KIND_A, rpss_pkg::KIND_B, rpss_pkg::KIND_C, rpss_pkg::KIND_D:
                r = e[rpss_pkg::ROW_W-1:0];
            rpss_pkg::KIND_OTHER:
                r = rpss_pkg::ROW_W'(32'(play_row) + 32'd1 + 32'(rnd) % 32'd3);
            rpss_pkg::KIND_ANY:
                r = rnd[rpss_pkg::ROW_W-1:0];
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // Enter the row of an entry at its first step in the entry's direction.
    function automatic void enter_entry(input logic [rpss_pkg::ENTRY_W-1:0] e,
                                        input logic [7:0] rnd);
        play_row = entry_row(e, rnd);
        if (e[rpss_pkg::ENTRY_BWD]) play_col = rpss_pkg::COL_W'(active_steps(play_row) - 1);
        else                        play_col = '0;
    endfunction

    // One clock step of the play position.
    function automatic void step_play(input logic [7:0] rnd);
        int unsigned span;
        int unsigned idx;
        int unsigned nidx;
        int unsigned len;
        logic        fwd;
        logic        at_end;
        span = program_span();
        // An index left past a shortened program reads entry zero.
        idx  = (prog_pos < span) ? prog_pos : 0;
        fwd  = (span == 0) ? 1'b1 : !prog_mem[idx][rpss_pkg::ENTRY_BWD];
        len  = active_steps(play_row);
        at_end = 1'b0;
        if (fwd) begin
            if (play_col + 1 < len) play_col = play_col + 1'b1;
            else                    at_end = 1'b1;
        end
        else begin
            if (play_col > 0) play_col = play_col - 1'b1;
            else              at_end = 1'b1;
        end
        if (!at_end) return;
        if (span == 0) begin
            // With no program the rows simply take turns, each played forwards.
            play_row = play_row + 1'b1;
            play_col = '0;
            prog_pos = '0;
        end
        else begin
            nidx = (idx + 1 >= span) ? 0 : idx + 1;
            enter_entry(prog_mem[nidx], rnd);
            prog_pos = rpss_pkg::PROG_AW'(nidx);
        end
    endfunction

    // Pending reset request: back to the program start. An empty program only
    // selects row A and keeps the column.
    function automatic void restart_program(input logic [7:0] rnd);
        prog_pos = '0;
        if (program_span() > 0) enter_entry(prog_mem[0], rnd);
        else                    play_row = '0;
    endfunction

    // Apply one item to the model and return the result it produces.
    function automatic rpss_pkg::result_t sequencer_step(input rpss_pkg::item_t it);
        rpss_pkg::result_t           res;
        logic                        pulse_on;
        logic                        adv;
        logic                        gate;
        logic [rpss_pkg::CELL_W-1:0] cell_idx;
        res      = '0;
        adv      = 1'b0;
        pulse_on = (pulse_left != 0);
        case (it.func)
            rpss_pkg::FUNC_CLOCK: begin
                if (run_reg) begin
                    adv = 1'b1;
                    step_play(it.random_value);
                    if (restart_due) begin
                        restart_due = 1'b0;
                        restart_program(it.random_value);
                    end
                    if (ticks_reg > pulse_left) pulse_left = ticks_reg;
                    pulse_on = (pulse_left != 0);
                end
            end
            rpss_pkg::FUNC_RESET:  restart_due = 1'b1;
            rpss_pkg::FUNC_TOGGLE: cell_gate[it.cell_req] = ~cell_gate[it.cell_req];
            rpss_pkg::FUNC_WRITE:  prog_mem[it.slot] = {it.backward, it.row_kind};
            rpss_pkg::FUNC_LOAD:   cell_gate = it.gate_mask;
            // The pulse level of a tick is the one before the count goes down.
            rpss_pkg::FUNC_TICK:   if (pulse_left != 0) pulse_left = pulse_left - 1'b1;
            default: ;
        endcase
        cell_idx = rpss_pkg::CELL_W'(play_col + play_row * rpss_pkg::COLUMNS);
        gate = run_reg && cell_gate[cell_idx];
        if (mode_reg == rpss_pkg::MODE_TRIGGER)        gate = gate && pulse_on;
        else if (mode_reg == rpss_pkg::MODE_RETRIGGER) gate = gate && !pulse_on;
        res.cell_index = cell_idx;
        res.gate_out   = gate;
        res.advanced   = adv;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Reporting.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (printed < MAX_PRINTED) begin
            $display("MISMATCH @%0t ns, result %0d: %s expected %0d, got %0d",
                     $time, results_checked, what, want, got);
            printed++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking. Every result transfer is matched against the oldest
    // prediction. Signals are sampled at the edge, before the block or the
    // bench updates them.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && result_bus.valid && result_bus.ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing awaited, cell_index",
                                -1, result_bus.cell_index);
            end
            else begin
                due = awaited_results.pop_front();
                if (result_bus.cell_index !== due.cell_index)
                    report_mismatch("cell_index", due.cell_index, result_bus.cell_index);
                if (result_bus.gate_out !== due.gate_out)
                    report_mismatch("gate_out", due.gate_out, result_bus.gate_out);
                if (result_bus.advanced !== due.advanced)
                    report_mismatch("advanced", due.advanced, result_bus.advanced);
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side. For every result it draws a stall, and it honors a long
    // hold-off when a test asks for one. The hold-off is counted here.
    // ------------------------------------------------------------------
    initial begin
        int stall;
        result_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end
            else begin
                stall = steady ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (stall > 0) begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do @(posedge clk); while (!result_bus.valid);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog. It counts edges with no transfer on any channel.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (item_bus.valid && item_bus.ready) ||
            (result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results still awaited",
                     quiet_cycles, awaited_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Item side.
    // ------------------------------------------------------------------

    // Offer one item after a random gap and wait for its transfer. Valid stays
    // high after the transfer, so the next call can follow without a bubble.
    // Anything that lets time pass without sending lowers valid first.
    task automatic send_item(input rpss_pkg::item_t it);
        int                gap;
        rpss_pkg::result_t predicted;
        gap = steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid        <= 1'b1;
        item_bus.func         <= it.func;
        item_bus.cell_req     <= it.cell_req;
        item_bus.slot         <= it.slot;
        item_bus.row_kind     <= it.row_kind;
        item_bus.backward     <= it.backward;
        item_bus.random_value <= it.random_value;
        item_bus.gate_mask    <= it.gate_mask;
        do @(posedge clk); while (!item_bus.ready);
        predicted = sequencer_step(it);
        awaited_results.insert(awaited_results.size(), predicted);
        items_sent++;
    endtask

    // Stop sending and wait until every predicted result has arrived, then let
    // the pipeline settle.
    task automatic wait_drain();
        item_bus.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write. Valid is lowered again after the transfer, before the
    // next write can raise it.
    task automatic write_reg(input logic [rpss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rpss_pkg::CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        case (idx)
            rpss_pkg::CFG_ROW_LEN_A, rpss_pkg::CFG_ROW_LEN_B,
            rpss_pkg::CFG_ROW_LEN_C, rpss_pkg::CFG_ROW_LEN_D:
                len_reg[idx[1:0]] = value[rpss_pkg::RLEN_W-1:0];
            rpss_pkg::CFG_PROG_LEN:    plen_reg  = value[rpss_pkg::PLCFG_W-1:0];
            rpss_pkg::CFG_GATE_MODE:   mode_reg  = value[rpss_pkg::MODE_W-1:0];
            rpss_pkg::CFG_PULSE_TICKS: ticks_reg = value[rpss_pkg::TICKS_W-1:0];
            rpss_pkg::CFG_RUN_ENABLE:  run_reg   = value[0];
            default: ;
        endcase
        reg_writes++;
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Write all registers once the block is idle.
    task automatic configure(input logic [rpss_pkg::RLEN_W-1:0] la,
                             input logic [rpss_pkg::RLEN_W-1:0] lb,
                             input logic [rpss_pkg::RLEN_W-1:0] lc,
                             input logic [rpss_pkg::RLEN_W-1:0] ld,
                             input logic [rpss_pkg::PLCFG_W-1:0] pl,
                             input logic [rpss_pkg::MODE_W-1:0] mode,
                             input logic [rpss_pkg::TICKS_W-1:0] ticks, input logic run);
        wait_drain();
        write_reg(rpss_pkg::CFG_ROW_LEN_A, rpss_pkg::CFG_DATA_W'(la));
        write_reg(rpss_pkg::CFG_ROW_LEN_B, rpss_pkg::CFG_DATA_W'(lb));
        write_reg(rpss_pkg::CFG_ROW_LEN_C, rpss_pkg::CFG_DATA_W'(lc));
        write_reg(rpss_pkg::CFG_ROW_LEN_D, rpss_pkg::CFG_DATA_W'(ld));
        write_reg(rpss_pkg::CFG_PROG_LEN, rpss_pkg::CFG_DATA_W'(pl));
        write_reg(rpss_pkg::CFG_GATE_MODE, rpss_pkg::CFG_DATA_W'(mode));
        write_reg(rpss_pkg::CFG_PULSE_TICKS, ticks);
        write_reg(rpss_pkg::CFG_RUN_ENABLE, rpss_pkg::CFG_DATA_W'(run));
    endtask

    function automatic rpss_pkg::item_t make_item(input logic [rpss_pkg::FUNC_W-1:0] func,
                                        input logic [4:0] cell_req, input logic [4:0] slot,
                                        input logic [rpss_pkg::KIND_W-1:0] kind,
                                        input logic bwd,
                                        input logic [7:0] rnd, input logic [31:0] mask);
        rpss_pkg::item_t it;
        it.func         = func;
        it.cell_req     = cell_req;
        it.slot         = slot;
        it.row_kind     = kind;
        it.backward     = bwd;
        it.random_value = rnd;
        it.gate_mask    = mask;
        return it;
    endfunction

    // Mostly the six defined row kinds, now and then a spare one.
    function automatic logic [rpss_pkg::KIND_W-1:0] random_kind();
        if ($urandom_range(0, 9) == 0) return rpss_pkg::KIND_W'($urandom_range(6, 7));
        return rpss_pkg::KIND_W'($urandom_range(0, 5));
    endfunction

    // A random item. Clocks and ticks dominate, so the position walks through
    // the program and the pulse expires. Program writes mostly land inside the
    // active program, so the program that plays keeps changing.
    function automatic rpss_pkg::item_t random_item();
        rpss_pkg::item_t it;
        int              pick;
        int unsigned     span;
        it   = make_item(rpss_pkg::FUNC_CLOCK, 5'($urandom), 5'($urandom), random_kind(),
                         1'($urandom), 8'($urandom), $urandom);
        span = program_span();
        if (span > 0 && $urandom_range(0, 3) != 0)
            it.slot = 5'($urandom_range(0, span - 1));
        pick = $urandom_range(0, 99);
        if (pick < 45)      it.func = rpss_pkg::FUNC_CLOCK;
        else if (pick < 65) it.func = rpss_pkg::FUNC_TICK;
        else if (pick < 77) it.func = rpss_pkg::FUNC_WRITE;
        else if (pick < 83) it.func = rpss_pkg::FUNC_RESET;
        else if (pick < 91) it.func = rpss_pkg::FUNC_TOGGLE;
        else if (pick < 97) it.func = rpss_pkg::FUNC_LOAD;
        else if (pick < 99) it.func = FUNC_SPARE_6;
        else                it.func = FUNC_SPARE_7;
        return it;
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_item(random_item());
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Directed items under the reset settings: the restart after reset, every
    // function including the spare codes, toggles and loads at the cell ends,
    // writes of every unusual entry, and clocks with the extreme random values.
    task automatic test_directed();
        send_item(make_item(rpss_pkg::FUNC_CLOCK, 5'd0, 5'd0, rpss_pkg::KIND_A, 1'b0,
                            8'h00, 32'h0));
        send_item(make_item(rpss_pkg::FUNC_TICK, 5'd0, 5'd0, rpss_pkg::KIND_A, 1'b0,
                            8'h00, 32'h0));
        send_item(make_item(rpss_pkg::FUNC_CLOCK, 5'd0, 5'd0, rpss_pkg::KIND_A, 1'b0,
                            8'hFF, 32'h0));
        send_item(make_item(FUNC_SPARE_6, 5'd0, 5'd0, rpss_pkg::KIND_A, 1'b0, 8'h00, 32'h0));
        send_item(make_item(FUNC_SPARE_7, 5'd31, 5'd31, KIND_SPARE_7, 1'b1, 8'hFF, '1));
        send_item(make_item(rpss_pkg::FUNC_TOGGLE, 5'd0, 5'd0, rpss_pkg::KIND_A, 1'b0,
                            8'h00, 32'h0));
        send_item(make_item(rpss_pkg::FUNC_TOGGLE, 5'd31, 5'd0, rpss_pkg::KIND_A, 1'b0,
                            8'h00, 32'h0));
        send_item(make_item(rpss_pkg::FUNC_LOAD, 5'd0, 5'd0, rpss_pkg::KIND_A, 1'b0,
                            8'h00, 32'h0000_0000));
        send_item(make_item(rpss_pkg::FUNC_LOAD, 5'd0, 5'd0, rpss_pkg::KIND_A, 1'b0,
                            8'h00, 32'h5A5A_A5A5));
        send_item(make_item(rpss_pkg::FUNC_LOAD, 5'd0, 5'd0, rpss_pkg::KIND_A, 1'b0,
                            8'h00, 32'hFFFF_FFFF));
        send_item(make_item(rpss_pkg::FUNC_WRITE, 5'd0, 5'd0, rpss_pkg::KIND_OTHER, 1'b1,
                            8'h00, 32'h0));
        send_item(make_item(rpss_pkg::FUNC_WRITE, 5'd0, 5'd1, rpss_pkg::KIND_ANY, 1'b0,
                            8'h00, 32'h0));
        send_item(make_item(rpss_pkg::FUNC_WRITE, 5'd0, 5'd2, KIND_SPARE_6, 1'b1,
                            8'h00, 32'h0));
        send_item(make_item(rpss_pkg::FUNC_WRITE, 5'd0, 5'd3, rpss_pkg::KIND_D, 1'b1,
                            8'h00, 32'h0));
        // An entry past the reset program length is stored but not played here.
        send_item(make_item(rpss_pkg::FUNC_WRITE, 5'd0, 5'd31, KIND_SPARE_7, 1'b0,
                            8'h00, 32'h0));
        send_item(make_item(rpss_pkg::FUNC_RESET, 5'd0, 5'd0, rpss_pkg::KIND_A, 1'b0,
                            8'h00, 32'h0));
        // The first clock after the request goes to the program start, whose
        // entry is "other row" played backwards. The rest cover every remainder
        // of the random value.
        send_item(make_item(rpss_pkg::FUNC_CLOCK, 5'd0, 5'd0, rpss_pkg::KIND_A, 1'b0,
                            8'd0, 32'h0));
        send_item(make_item(rpss_pkg::FUNC_CLOCK, 5'd0, 5'd0, rpss_pkg::KIND_A, 1'b0,
                            8'd1, 32'h0));
        send_item(make_item(rpss_pkg::FUNC_CLOCK, 5'd0, 5'd0, rpss_pkg::KIND_A, 1'b0,
                            8'd2, 32'h0));
        send_item(make_item(rpss_pkg::FUNC_CLOCK, 5'd0, 5'd0, rpss_pkg::KIND_A, 1'b0,
                            8'd3, 32'h0));
        send_item(make_item(rpss_pkg::FUNC_CLOCK, 5'd0, 5'd0, rpss_pkg::KIND_A, 1'b0,
                            8'd255, 32'h0));
        send_item(make_item(rpss_pkg::FUNC_CLOCK, 5'd0, 5'd0, rpss_pkg::KIND_A, 1'b0,
                            8'd128, 32'h0));
        send_item(make_item(rpss_pkg::FUNC_CLOCK, 5'd0, 5'd0, rpss_pkg::KIND_A, 1'b0,
                            8'd85, 32'h0));
        send_item(make_item(rpss_pkg::FUNC_CLOCK, 5'd0, 5'd0, rpss_pkg::KIND_A, 1'b0,
                            8'd170, 32'h0));
    endtask

    // Settings at the edges of the register ranges. Each setting is followed
    // by random items.
    task automatic test_config_extremes();
        // Single-step rows and a one-entry program. The pulse lasts one tick.
        configure(4'd1, 4'd1, 4'd1, 4'd1, 6'd1, rpss_pkg::MODE_RETRIGGER, 16'd1, 1'b1);
        run_random(60);
        // Full rows, a full program, the longest pulse, and no idling.
        steady = 1'b1;
        configure(4'd8, 4'd8, 4'd8, 4'd8, 6'd32, MODE_CONTINUOUS, 16'hFFFF, 1'b1);
        run_random(60);
        steady = 1'b0;
        // Lengths clamped from zero and from fifteen, under an empty program.
        configure(4'd0, 4'd15, 4'd0, 4'd15, 6'd0, rpss_pkg::MODE_TRIGGER, 16'd2, 1'b1);
        run_random(60);
        // The program length saturates at the store depth. The spare gate mode
        // acts as continuous.
        steady = 1'b1;
        configure(4'd3, 4'd5, 4'd7, 4'd2, 6'd63, MODE_SPARE, 16'd3, 1'b1);
        run_random(60);
        steady = 1'b0;
        // Stopped. Clocks are ignored and gates are silent, but reset requests
        // still stick.
        configure(4'd2, 4'd3, 4'd4, 4'd5, 6'd3, MODE_CONTINUOUS, 16'd2, 1'b0);
        run_random(40);
        // A zero pulse length never raises the pulse.
        configure(4'd8, 4'd1, 4'd6, 4'd4, 6'd5, rpss_pkg::MODE_TRIGGER, 16'd0, 1'b1);
        run_random(60);
    endtask

    // Random settings. Each one starts by writing a fresh program into up to
    // eight of its active entries, and then plays it with random items.
    task automatic test_random_settings();
        int unsigned span;
        for (int ph = 0; ph < 8; ph++) begin
            steady = (ph % 3 == 2);
            configure(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                      ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 8)) : 6'($urandom),
                      rpss_pkg::MODE_W'($urandom),
                      ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6)),
                      $urandom_range(0, 9) != 0);
            span = program_span();
            for (int s = 0; s < span && s < 8; s++)
                send_item(make_item(rpss_pkg::FUNC_WRITE, 5'($urandom), 5'(s), random_kind(),
                                    1'($urandom), 8'($urandom), $urandom));
            run_random(56);
        end
        steady = 1'b0;
    endtask

    // The result side holds off for a long stretch while items keep coming
    // back to back. The block fills up and must stall its input without losing
    // or reordering anything.
    task automatic test_backpressure();
        configure(4'd4, 4'd6, 4'd8, 4'd3, 6'd4, rpss_pkg::MODE_TRIGGER, 16'd3, 1'b1);
        steady       = 1'b1;
        hold_request = HOLD_OFF_CYCLES;
        run_random(40);
        steady = 1'b0;
    endtask

    // The sender pauses in the middle of a stream until every result is in,
    // then goes on without touching the registers.
    task automatic test_sender_pause();
        run_random(20);
        wait_drain();
        run_random(20);
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------
    initial begin
        item_bus.valid        <= 1'b0;
        item_bus.func         <= rpss_pkg::FUNC_CLOCK;
        item_bus.cell_req     <= '0;
        item_bus.slot         <= '0;
        item_bus.row_kind     <= rpss_pkg::KIND_A;
        item_bus.backward     <= 1'b0;
        item_bus.random_value <= '0;
        item_bus.gate_mask    <= '0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= rpss_pkg::CFG_ROW_LEN_A;
        cfg_bus.data          <= '0;
        reset_model();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_extremes();
        test_random_settings();
        test_backpressure();
        test_sender_pause();

        wait_drain();
        if (awaited_results.size() != 0)
            report_mismatch("results never delivered", awaited_results.size(), 0);

        $display("Summary: %0d items, %0d results checked, %0d register writes, %0d mismatches",
                 items_sent, results_checked, reg_writes, mismatches);
        $display("Covered: all functions, all row kinds, empty and saturated programs, %s",
                 "all gate modes, stopped running, a long output stall and a drain pause");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
